// ===== src/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared widths, codes and parameter defaults of the contiguous block
// allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  // parameter defaults
  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned MAX_FILES_DEF  = 16;

  // field widths
  localparam int unsigned DISK_W  = 9;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned START_W = 8;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // register reset and index
  localparam logic [DISK_W-1:0] DISK_RESET = 9'd256;
  localparam logic [0:0]        REG_DISK   = 1'b0;

  // commands
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO_LEN   = 3'd4;

endpackage

// ===== src/contiguous_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit
// First-fit contiguous block allocator with a used-block bitmap and a
// file table whose slots are never reused.
//
//   channel  direction  handshake                word
//   in       in         in_valid_i / in_stall_o  command_i, file_id_i, length_i
//   out      out        out_valid_o / out_stall_i status_o, start_block_o,
//                                                 run_length_o
//   cfg      in         APB psel/penable/pready  disk_blocks at byte address 0
//
// After reset the bitmap RAM is cleared one block a cycle with in_stall_o high.
// An add scans the bitmap of the blocks in use one bit a cycle through the
// bitmap RAM read port, then marks the run; zero length or a full table
// answer without a scan. A delete scans the file table, then frees the run.
// One word is worked on at a time.
// A held result stalls the block only in its final state, S_DONE.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit import cba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned MAX_FILES  = MAX_FILES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input word
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [ID_W-1:0]    file_id_i,
  input  logic [LEN_W-1:0]   length_i,
  // result word
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ST_W-1:0]    status_o,
  output logic [START_W-1:0] start_block_o,
  output logic [LEN_W-1:0]   run_length_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned BW   = $clog2(MAX_BLOCKS);
  localparam int unsigned NW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SIW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned SCW  = $clog2(MAX_FILES + 1);
  localparam int unsigned CMPW = (NW > DISK_W) ? NW : DISK_W;
  localparam int unsigned XW   = (BW > LEN_W) ? BW : LEN_W;
  localparam int unsigned PW   = (BW > START_W) ? BW : START_W;
  localparam int unsigned TW   = ID_W + BW + LEN_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ASCAN = 3'd2;
  localparam logic [2:0] S_AMARK = 3'd3;
  localparam logic [2:0] S_DSCAN = 3'd4;
  localparam logic [2:0] S_DFREE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [DISK_W-1:0]    disk_q;
  logic [ID_W-1:0]      id_q, id_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [BW-1:0]        start_q, start_d;
  logic [LEN_W-1:0]     run_q, run_d;
  logic [LEN_W-1:0]     k_q, k_d;
  logic [NW-1:0]        a_q, a_d;
  logic [SCW-1:0]       s_q, s_d;
  logic                 pend_q, pend_d;
  logic [BW-1:0]        btag_q, btag_d;
  logic [SIW-1:0]       stag_q, stag_d;
  logic [SCW-1:0]       slots_q, slots_d;
  logic [MAX_FILES-1:0] active_q, active_d;
  logic [ST_W-1:0]      res_q, res_d;
  logic                 out_valid_q;
  logic                 out_load;

  logic                 bm_we;
  logic [BW-1:0]        bm_waddr;
  logic [0:0]           bm_wdata;
  logic [0:0]           bm_rdata;
  logic                 tb_we;
  logic [TW-1:0]        tb_wdata;
  logic [TW-1:0]        tb_rdata;
  logic [ID_W-1:0]      tb_id;
  logic [BW-1:0]        tb_start;
  logic [LEN_W-1:0]     tb_len;

  logic [CMPW-1:0]      n_wide;
  logic [NW-1:0]        n_lim;
  logic [XW-1:0]        mark_sum;
  logic [LEN_W-1:0]     run_inc;
  logic [BW-1:0]        run_start;
  logic [PW-1:0]        start_ext;
  logic                 cfg_wr;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DISK);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DISK) ? APB_DW'(disk_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= DISK_RESET;
    end else if (cfg_wr) begin
      disk_q <= pwdata[DISK_W-1:0];
    end
  end

  // blocks in use, clamped to the bitmap size
  assign n_wide = (CMPW'(disk_q) > CMPW'(MAX_BLOCKS)) ? CMPW'(MAX_BLOCKS) : CMPW'(disk_q);
  assign n_lim  = n_wide[NW-1:0];

  // shared address adder for marking and freeing runs
  assign mark_sum  = XW'(start_q) + XW'(k_q);
  assign run_inc   = run_q + LEN_W'(1);
  assign run_start = (run_q == '0) ? btag_q : start_q;
  assign start_ext = PW'(start_q);

  // table word layout: id, start, length
  assign tb_id    = tb_rdata[TW-1 -: ID_W];
  assign tb_start = tb_rdata[BW+LEN_W-1 : LEN_W];
  assign tb_len   = tb_rdata[LEN_W-1:0];
  assign tb_wdata = {id_q, run_start, len_q};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    id_d     = id_q;
    len_d    = len_q;
    start_d  = start_q;
    run_d    = run_q;
    k_d      = k_q;
    a_d      = a_q;
    s_d      = s_q;
    pend_d   = pend_q;
    btag_d   = btag_q;
    stag_d   = stag_q;
    slots_d  = slots_q;
    active_d = active_q;
    res_d    = res_q;
    out_load = 1'b0;
    bm_we    = 1'b0;
    bm_waddr = mark_sum[BW-1:0];
    bm_wdata = 1'b0;
    tb_we    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = a_q[BW-1:0];
        a_d      = a_q + NW'(1);
        if (a_q == NW'(MAX_BLOCKS - 1)) begin
          a_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          id_d   = file_id_i;
          len_d  = length_i;
          run_d  = '0;
          a_d    = '0;
          s_d    = '0;
          pend_d = 1'b0;
          if (command_i == CMD_DELETE) begin
            state_d = S_DSCAN;
          end else if (length_i == '0) begin
            res_d   = ST_ZERO_LEN;
            state_d = S_DONE;
          end else if (slots_q == SCW'(MAX_FILES)) begin
            res_d   = ST_TABLE_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        // issue the next bitmap read
        pend_d = 1'b0;
        if (a_q < n_lim) begin
          pend_d = 1'b1;
          btag_d = a_q[BW-1:0];
          a_d    = a_q + NW'(1);
        end
        // look at the bit read last cycle
        if (pend_q) begin
          if (bm_rdata[0]) begin
            run_d = '0;
          end else begin
            run_d   = run_inc;
            start_d = run_start;
            if (run_inc == len_q) begin
              tb_we    = 1'b1;
              active_d[slots_q[SIW-1:0]] = 1'b1;
              slots_d  = slots_q + SCW'(1);
              k_d      = '0;
              pend_d   = 1'b0;
              state_d  = S_AMARK;
            end
          end
        end else if (a_q >= n_lim) begin
          res_d   = ST_NO_SPACE;
          state_d = S_DONE;
        end
      end
      S_AMARK: begin
        bm_we    = 1'b1;
        bm_wdata = 1'b1;
        k_d      = k_q + LEN_W'(1);
        if (k_q == len_q - LEN_W'(1)) begin
          res_d   = ST_OK;
          state_d = S_DONE;
        end
      end
      S_DSCAN: begin
        // issue the next table read
        pend_d = 1'b0;
        if (s_q < slots_q) begin
          pend_d = 1'b1;
          stag_d = s_q[SIW-1:0];
          s_d    = s_q + SCW'(1);
        end
        // compare the slot read last cycle
        if (pend_q) begin
          if (active_q[stag_q] && (tb_id == id_q)) begin
            start_d          = tb_start;
            len_d            = tb_len;
            active_d[stag_q] = 1'b0;
            k_d              = '0;
            pend_d           = 1'b0;
            state_d          = S_DFREE;
          end
        end else if (s_q >= slots_q) begin
          res_d   = ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end
      S_DFREE: begin
        bm_we    = 1'b1;
        bm_wdata = 1'b0;
        k_d      = k_q + LEN_W'(1);
        if (k_q == len_q - LEN_W'(1)) begin
          res_d   = ST_OK;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      a_q      <= '0;
      s_q      <= '0;
      pend_q   <= 1'b0;
      slots_q  <= '0;
      active_q <= '0;
    end else begin
      state_q  <= state_d;
      a_q      <= a_d;
      s_q      <= s_d;
      pend_q   <= pend_d;
      slots_q  <= slots_d;
      active_q <= active_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    len_q   <= len_d;
    start_q <= start_d;
    run_q   <= run_d;
    k_q     <= k_d;
    btag_q  <= btag_d;
    stag_q  <= stag_d;
    res_q   <= res_d;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload, zeros on error
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o      <= res_q;
      start_block_o <= (res_q == ST_OK) ? start_ext[START_W-1:0] : '0;
      run_length_o  <= (res_q == ST_OK) ? len_q : '0;
    end
  end

  // used-block bitmap
  cba_ram #(
    .WIDTH(1),
    .DEPTH(MAX_BLOCKS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (bm_we),
    .waddr_i(bm_waddr),
    .wdata_i(bm_wdata),
    .raddr_i(a_q[BW-1:0]),
    .rdata_o(bm_rdata)
  );

  // file table
  cba_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_FILES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tb_we),
    .waddr_i(slots_q[SIW-1:0]),
    .wdata_i(tb_wdata),
    .raddr_i(s_q[SIW-1:0]),
    .rdata_o(tb_rdata)
  );

`ifndef SYNTHESIS
  // slot counter never passes the table size
  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_q <= SCW'(MAX_FILES))
    else $error("slot counter beyond table size");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

  // marked or freed blocks stay inside the bitmap
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_AMARK) || (state_q == S_DFREE)) |-> (mark_sum < XW'(MAX_BLOCKS)))
    else $error("run address outside bitmap");

  // a result appears only from the final state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result without finished word");

  // no result during the clearing pass
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_o)
    else $error("result during bitmap clear");
`endif

endmodule

// ===== src/cba_ram.sv =====
// ----------------------------------------------------------------------------
// cba_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== bench/contiguous_block_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit_tb
// Self-checking bench for the first-fit block allocator. A tracker object
// keeps its own bitmap and file table, works out the outcome of every
// accepted add or delete word and checks each result word against it in
// order. A directed opening covers the corner cases, then random traffic
// runs over several disk sizes with bursty input and a shifting output stall.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit_tb import cba_pkg::*; ();

  localparam int unsigned N_BLOCKS    = MAX_BLOCKS_DEF;
  localparam int unsigned N_FILES     = MAX_FILES_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 600;
  localparam int unsigned PHASE_WORDS = 250;
  localparam logic [APB_AW-1:0] DISK_ADDR = APB_AW'(4 * int'(REG_DISK));

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  // tracks the allocator state and the outcomes still owed
  class alloc_tracker;
    typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
    } outcome_t;

    logic [DISK_W-1:0] disk_size;
    bit                used_map [N_BLOCKS];
    logic [ID_W-1:0]   slot_id [N_FILES];
    int unsigned       slot_start [N_FILES];
    int unsigned       slot_len [N_FILES];
    bit                slot_live [N_FILES];
    int unsigned       slots_filled;
    outcome_t          owed_outcomes [$];
    int unsigned       error_count;
    int unsigned       add_count;
    int unsigned       delete_count;
    int unsigned       status_hits [5];

    function new();
      disk_size    = DISK_RESET;
      slots_filled = 0;
      error_count  = 0;
      add_count    = 0;
      delete_count = 0;
      foreach (used_map[b]) used_map[b] = 1'b0;
      foreach (slot_live[s]) slot_live[s] = 1'b0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_disk(logic [DISK_W-1:0] size);
      disk_size = size;
    endfunction

    function int unsigned outstanding();
      return owed_outcomes.size();
    endfunction

    function void count_error(string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // first-fit scan of the bitmap within the disk in use
    function outcome_t first_fit_add(logic [ID_W-1:0] id, int unsigned len);
      outcome_t    res;
      int unsigned span, run, run_start, b;
      bit          found;
      res       = '0;
      span      = (disk_size > N_BLOCKS) ? N_BLOCKS : disk_size;
      run       = 0;
      run_start = 0;
      found     = 1'b0;
      if (len == 0) begin
        res.status = ST_ZERO_LEN;
        return res;
      end
      if (slots_filled >= N_FILES) begin
        res.status = ST_TABLE_FULL;
        return res;
      end
      for (b = 0; b < span && !found; b++) begin
        if (used_map[b]) begin
          run = 0;
        end else begin
          if (run == 0) run_start = b;
          run++;
          if (run == len) found = 1'b1;
        end
      end
      if (!found) begin
        res.status = ST_NO_SPACE;
        return res;
      end
      for (b = run_start; b < run_start + len; b++) used_map[b] = 1'b1;
      slot_id[slots_filled]    = id;
      slot_start[slots_filled] = run_start;
      slot_len[slots_filled]   = len;
      slot_live[slots_filled]  = 1'b1;
      slots_filled++;
      res.status = ST_OK;
      res.start  = START_W'(run_start);
      res.length = LEN_W'(len);
      return res;
    endfunction

    // lowest live slot with this id gives back its whole run
    function outcome_t release_file(logic [ID_W-1:0] id);
      outcome_t    res;
      int unsigned s, b;
      res = '0;
      for (s = 0; s < slots_filled; s++) begin
        if (slot_live[s] && slot_id[s] == id) begin
          for (b = slot_start[s]; b < slot_start[s] + slot_len[s]; b++) begin
            if (b < N_BLOCKS) used_map[b] = 1'b0;
          end
          slot_live[s] = 1'b0;
          res.status   = ST_OK;
          res.start    = START_W'(slot_start[s]);
          res.length   = LEN_W'(slot_len[s]);
          return res;
        end
      end
      res.status = ST_NOT_FOUND;
      return res;
    endfunction

    function void note_word(logic cmd, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
      outcome_t res;
      if (cmd == CMD_ADD) begin
        res = first_fit_add(id, len);
        add_count++;
      end else begin
        res = release_file(id);
        delete_count++;
      end
      status_hits[res.status]++;
      owed_outcomes.push_back(res);
    endfunction

    function void check_word(outcome_t got);
      outcome_t want;
      if (owed_outcomes.size() == 0) begin
        count_error($sformatf("result word with none owed: status %0d start %0d length %0d",
                              got.status, got.start, got.length));
        return;
      end
      want = owed_outcomes.pop_front();
      if (got.status !== want.status || got.start !== want.start ||
          got.length !== want.length) begin
        count_error($sformatf("expected status %0d start %0d length %0d, got %0d %0d %0d",
                              want.status, want.start, want.length,
                              got.status, got.start, got.length));
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               command_i     = CMD_ADD;
  logic [ID_W-1:0]    file_id_i     = '0;
  logic [LEN_W-1:0]   length_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [ST_W-1:0]    status_o;
  logic [START_W-1:0] start_block_o;
  logic [LEN_W-1:0]   run_length_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [APB_AW-1:0]  paddr         = '0;
  logic [APB_DW-1:0]  pwdata        = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  alloc_tracker       tracker;
  int unsigned        burst_left    = 0;
  int unsigned        disk_writes   = 0;
  stall_style_e       stall_style   = STALL_NONE;
  int unsigned        stall_left    = 0;
  int unsigned        stall_tick    = 0;
  logic [ID_W-1:0]    id_pool [8];

  contiguous_block_allocator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .file_id_i     (file_id_i),
    .length_i      (length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .start_block_o (start_block_o),
    .run_length_o  (run_length_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: check accepted words, stall in changing styles
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_word({status_o, start_block_o, run_length_o});
    end
    if (stall_left == 0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
      stall_left  <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_tick % 5) < 2);
    endcase
    stall_tick <= stall_tick + 1;
  end

  // watchdog on cycles with no word moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("contiguous_block_allocator_unit_tb: done, errors");
    $finish;
  end

  // one input word, sent in bursts with random gaps in between
  task automatic send_word(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [LEN_W-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    file_id_i  <= id;
    length_i   <= len;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_word(cmd, id, len);
  endtask

  // hold off input until every owed result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  // write the disk size over APB once idle, then read it back
  task automatic set_disk_size(input logic [DISK_W-1:0] size);
    drain_results();
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DISK_ADDR;
    pwdata  <= APB_DW'(size);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_disk(size);
    disk_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[DISK_W-1:0] !== size) begin
      tracker.count_error($sformatf("disk size read back %0d, wrote %0d",
                                    prdata[DISK_W-1:0], size));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random word: ids mostly from a small pool so deletes find their files
  task automatic random_word();
    int unsigned     pick, sel;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 99);
    id   = id_pool[$urandom_range(0, 7)];
    len  = LEN_W'($urandom);
    if (pick < 45) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) len = LEN_W'($urandom_range(1, 16));
      else if (sel == 7) len = '0;
      else if (sel == 8) len = LEN_W'($urandom_range(17, 256));
      send_word(CMD_ADD, id, len);
    end else begin
      if (pick >= 90) id = ID_W'($urandom);
      send_word(CMD_DELETE, id, len);
    end
  endtask

  // main sequence
  initial begin : main_seq
    int unsigned phase_size [4];
    int unsigned ph, k;
    tracker = new();
    rst_ni  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at the reset disk size
    send_word(CMD_ADD,    16'h0000, 9'd0);     // zero length
    send_word(CMD_DELETE, 16'hFFFF, 9'h1FF);   // unknown id
    send_word(CMD_ADD,    16'hFFFF, 9'd256);   // whole disk
    send_word(CMD_ADD,    16'h0001, 9'd1);     // disk full
    send_word(CMD_DELETE, 16'hFFFF, 9'd0);     // frees everything
    send_word(CMD_ADD,    16'h0005, 9'h1FF);   // longer than the disk
    send_word(CMD_ADD,    16'h0005, 9'd3);
    send_word(CMD_ADD,    16'h0005, 9'd2);     // duplicate id
    send_word(CMD_ADD,    16'h0006, 9'd4);
    send_word(CMD_DELETE, 16'h0005, 9'd0);     // lowest slot of the duplicates
    send_word(CMD_ADD,    16'h0007, 9'd2);     // fits the freed hole
    send_word(CMD_ADD,    16'h0008, 9'd2);     // skips a one-block hole

    // disk size corners
    set_disk_size(9'd0);                       // empty disk
    send_word(CMD_ADD,    16'h0009, 9'd1);
    set_disk_size(9'h1FF);                     // above the maximum
    send_word(CMD_ADD,    16'h1234, 9'd200);
    set_disk_size(9'd12);                      // shrunk below a live run
    send_word(CMD_ADD,    16'h000A, 9'd2);
    send_word(CMD_DELETE, 16'h1234, 9'd0);
    set_disk_size(9'd1);
    send_word(CMD_ADD,    16'h000B, 9'd1);
    send_word(CMD_DELETE, 16'h0005, 9'd0);

    // random traffic over several disk sizes
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (k = 2; k < 8; k++) id_pool[k] = ID_W'($urandom);
    phase_size[0] = $urandom_range(8, 64);
    phase_size[1] = 1;
    phase_size[2] = N_BLOCKS;
    phase_size[3] = $urandom_range(100, 255);
    for (ph = 0; ph < 4; ph++) begin
      set_disk_size(DISK_W'(phase_size[ph]));
      for (k = 0; k < PHASE_WORDS; k++) begin
        random_word();
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    // wind down
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.outstanding() != 0) begin
      tracker.count_error($sformatf("%0d results never arrived", tracker.outstanding()));
    end
    $display("covered %0d adds and %0d deletes across %0d disk size writes",
             tracker.add_count, tracker.delete_count, disk_writes);
    $display("outcomes: ok %0d, no space %0d, table full %0d, not found %0d, zero length %0d",
             tracker.status_hits[ST_OK], tracker.status_hits[ST_NO_SPACE],
             tracker.status_hits[ST_TABLE_FULL], tracker.status_hits[ST_NOT_FOUND],
             tracker.status_hits[ST_ZERO_LEN]);
    if (tracker.error_count == 0) begin
      $display("contiguous_block_allocator_unit_tb: done, clean");
    end else begin
      $display("contiguous_block_allocator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
